>>> rtl/dcsc_pkg.sv
// Shared types, constants and small helper functions for the civil date /
// serial day converter: stage count, status codes, reciprocal factors and
// month tables. Depends on nothing.
package dcsc_pkg;

  localparam int unsigned NSTG = 10;

  typedef logic [NSTG-1:0] stg_en_t;
  typedef logic [2:0]      status_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_BAD_MONTH  = 3'd1;
  localparam status_t ST_BAD_DAY    = 3'd2;
  localparam status_t ST_BAD_YEAR   = 3'd3;
  localparam status_t ST_BAD_SERIAL = 3'd4;

  localparam int SERIAL_OFFSET = 693594;
  localparam int SERIAL_MIN    = -693593;
  localparam int SERIAL_MAX    = 2958465;
  localparam int unsigned MAX_YEAR   = 9999;
  localparam int unsigned NUM_MONTHS = 12;

  localparam int unsigned DAYS_1Y   = 365;
  localparam int unsigned DAYS_4Y   = DAYS_1Y * 4 + 1;
  localparam int unsigned DAYS_100Y = DAYS_4Y * 25 - 1;
  localparam int unsigned DAYS_400Y = DAYS_100Y * 4 + 1;

  localparam int unsigned YEARS_4   = 4;
  localparam int unsigned YEARS_100 = 100;
  localparam int unsigned YEARS_400 = 400;
  localparam int unsigned CENT_DIV  = 25;

  localparam logic signed [22:0] SER_LO = 23'(SERIAL_MIN);
  localparam logic signed [22:0] SER_HI = 23'(SERIAL_MAX);

  // Reciprocal factors: floor(x / D) = (x * MUL) >> SH over the ranges used here
  localparam int unsigned DIV25_SH  = 17;
  localparam int unsigned DIV25_MUL = ((1 << DIV25_SH) + CENT_DIV - 1) / CENT_DIV;
  localparam int unsigned DIV4Y_SH  = 26;
  localparam int unsigned DIV4Y_MUL = ((1 << DIV4Y_SH) + DAYS_4Y - 1) / DAYS_4Y;
  localparam int unsigned DIV31_SH  = 15;
  localparam int unsigned DIV31_MUL = ((1 << DIV31_SH) + 31 - 1) / 31;
  localparam int unsigned DIV400Y_SH = 39;
  localparam longint unsigned DIV400Y_MUL =
      ((64'd1 << DIV400Y_SH) + DAYS_400Y - 1) / DAYS_400Y;

  // x / 25 for x below 4096
  function automatic logic [7:0] div25(logic [11:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'(DIV25_MUL);
    return 8'(p >> DIV25_SH);
  endfunction

  // Leap test from the year and its precomputed quotients (y/4)/25 and (y/16)/25
  function automatic logic is_leap(logic [13:0] y, logic [7:0] q100, logic [7:0] q400);
    logic mod4;
    logic c100;
    logic c400;
    mod4 = (y[1:0] == 2'd0);
    c100 = (y[13:2] == 12'(12'(q100) * 12'(CENT_DIV)));
    c400 = (y[3:0] == 4'd0) && (y[13:4] == 10'(10'(q400) * 10'(CENT_DIV)));
    return mod4 && (!c100 || c400);
  endfunction

  // Length of month m (1..12); 0 for codes that are no month
  function automatic logic [4:0] month_len(logic lp, logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = lp ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before month index idx (0..12, 12 = whole year)
  function automatic logic [8:0] month_start(logic lp, logic [3:0] idx);
    logic [8:0] ms;
    unique case (idx)
      4'd0:    ms = 9'd0;
      4'd1:    ms = 9'd31;
      4'd2:    ms = 9'd59;
      4'd3:    ms = 9'd90;
      4'd4:    ms = 9'd120;
      4'd5:    ms = 9'd151;
      4'd6:    ms = 9'd181;
      4'd7:    ms = 9'd212;
      4'd8:    ms = 9'd243;
      4'd9:    ms = 9'd273;
      4'd10:   ms = 9'd304;
      4'd11:   ms = 9'd334;
      4'd12:   ms = 9'd365;
      default: ms = 9'd0;
    endcase
    if (lp && (idx >= 4'd2) && (idx <= 4'd12)) begin
      ms = ms + 9'd1;
    end
    return ms;
  endfunction

endpackage

>>> rtl/dcsc_encode.sv
// Encode datapath: year/month/day to serial day number with status, in
// NSTG enabled register stages. Depends on dcsc_pkg.
module dcsc_encode (
  input  logic              clk,
  input  dcsc_pkg::stg_en_t en,
  input  logic [13:0]       year,
  input  logic [3:0]        month,
  input  logic [4:0]        day,
  output logic [22:0]       serial,
  output dcsc_pkg::status_t status
);
  import dcsc_pkg::*;

  // stage 0
  logic [13:0] year_r0, i_r0;
  logic [3:0]  mon_r0;
  logic [4:0]  day_r0;
  logic [7:0]  yq100_r0, yq400_r0, iq100_r0, iq400_r0;
  logic [13:0] i_nxt;

  // stage 1
  logic [21:0] a_r1, a_nxt;
  logic [11:0] b_r1, b_nxt;
  logic [9:0]  msd_r1, msd_nxt;
  logic        kill_r1, kill_nxt;
  status_t     st_nxt;
  logic        lp;
  logic        zero;
  logic [4:0]  mlen;

  // stage 2 and on
  logic [22:0] ser_nxt;
  logic [22:0] n_sum;
  logic [22:0] ser_r [2:NSTG-1];
  status_t     st_r  [1:NSTG-1];

  assign i_nxt = year - 14'd1;

  always_comb begin
    lp   = is_leap(year_r0, yq100_r0, yq400_r0);
    mlen = month_len(lp, mon_r0);
    zero = (year_r0 == 14'd0) && (mon_r0 == 4'd0) && (day_r0 == 5'd0);
    priority if (zero) begin
      st_nxt = ST_OK;
    end else if ((mon_r0 == 4'd0) || (mon_r0 > 4'(NUM_MONTHS))) begin
      st_nxt = ST_BAD_MONTH;
    end else if ((day_r0 == 5'd0) || (day_r0 > mlen)) begin
      st_nxt = ST_BAD_DAY;
    end else if ((year_r0 == 14'd0) || (year_r0 > 14'(MAX_YEAR))) begin
      st_nxt = ST_BAD_YEAR;
    end else begin
      st_nxt = ST_OK;
    end
    kill_nxt = zero || (st_nxt != ST_OK);
    a_nxt    = 22'(i_r0) * 22'(DAYS_1Y);
    b_nxt    = 12'(i_r0[13:2]) - 12'(iq100_r0) + 12'(iq400_r0);
    msd_nxt  = 10'(month_start(lp, mon_r0 - 4'd1)) + 10'(day_r0);
  end

  always_comb begin
    n_sum   = 23'(a_r1) + 23'(b_r1) + 23'(msd_r1);
    ser_nxt = kill_r1 ? '0 : (n_sum - 23'(SERIAL_OFFSET));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      year_r0  <= year;
      mon_r0   <= month;
      day_r0   <= day;
      i_r0     <= i_nxt;
      yq100_r0 <= div25(year[13:2]);
      yq400_r0 <= div25(12'(year[13:4]));
      iq100_r0 <= div25(i_nxt[13:2]);
      iq400_r0 <= div25(12'(i_nxt[13:4]));
    end
    if (en[1]) begin
      a_r1    <= a_nxt;
      b_r1    <= b_nxt;
      msd_r1  <= msd_nxt;
      kill_r1 <= kill_nxt;
      st_r[1] <= st_nxt;
    end
    if (en[2]) begin
      ser_r[2] <= ser_nxt;
      st_r[2]  <= st_r[1];
    end
    // delay line to the output stage
    for (int k = 3; k < NSTG; k++) begin
      if (en[k]) begin
        ser_r[k] <= ser_r[k-1];
        st_r[k]  <= st_r[k-1];
      end
    end
  end

  assign serial = ser_r[NSTG-1];
  assign status = st_r[NSTG-1];

endmodule

>>> rtl/dcsc_decode.sv
// Decode datapath: serial day number to year/month/day, splitting into
// 400-, 100-, 4- and 1-year periods over NSTG stages. Depends on dcsc_pkg.
module dcsc_decode (
  input  logic              clk,
  input  dcsc_pkg::stg_en_t en,
  input  logic [22:0]       serial,
  output logic [13:0]       year,
  output logic [3:0]        month,
  output logic [4:0]        day,
  output logic              bad
);
  import dcsc_pkg::*;

  logic        bad_r [0:NSTG-1];

  logic [21:0] t_r0, t_r1;
  logic [4:0]  q400_r1;
  logic [17:0] d_r2;
  logic [15:0] d_r3, d_r4;
  logic [4:0]  q4_r4;
  logic [10:0] d_r5;
  logic [8:0]  d_r6, d_r7, d_r8;
  logic [3:0]  m0_r7, m0_r8;
  logic [7:0]  yq100_r7, yq400_r7;
  logic [8:0]  mshi_r8, mslo_r8;
  logic [13:0] y_r2, y_r3, y_r4, y_r5, y_r6, y_r7, y_r8, y_r9;
  logic [3:0]  mon_r9;
  logic [4:0]  day_r9;

  logic [23:0] t_wide;
  logic        bad_nxt;
  logic [43:0] p400;
  logic [1:0]  qc;
  logic [31:0] p4y;
  logic [1:0]  q1;
  logic [19:0] p31;
  logic [3:0]  m0_nxt;
  logic        lp;
  logic [3:0]  mon_nxt;
  logic [8:0]  dd;

  always_comb begin
    t_wide  = {serial[22], serial} + 24'(SERIAL_OFFSET - 1);
    bad_nxt = ($signed(serial) < SER_LO) || ($signed(serial) > SER_HI);
    p400    = 44'(t_r0) * 44'(DIV400Y_MUL);
    // quotient capped at 3 folds in the last day of a 400-year cycle
    qc      = 2'(d_r2 >= 18'(DAYS_100Y)) + 2'(d_r2 >= 18'(2 * DAYS_100Y))
            + 2'(d_r2 >= 18'(3 * DAYS_100Y));
    p4y     = 32'(d_r3) * 32'(DIV4Y_MUL);
    q1      = 2'(d_r5 >= 11'(DAYS_1Y)) + 2'(d_r5 >= 11'(2 * DAYS_1Y))
            + 2'(d_r5 >= 11'(3 * DAYS_1Y));
    p31     = 20'(d_r6) * 20'(DIV31_MUL);
    m0_nxt  = 4'(p31 >> DIV31_SH);
    if (m0_nxt > 4'(NUM_MONTHS - 1)) begin
      m0_nxt = 4'(NUM_MONTHS - 1);
    end
    lp = is_leap(y_r7, yq100_r7, yq400_r7);
    if (mshi_r8 <= d_r8) begin
      mon_nxt = m0_r8 + 4'd2;
      dd      = d_r8 - mshi_r8;
    end else begin
      mon_nxt = m0_r8 + 4'd1;
      dd      = d_r8 - mslo_r8;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_r0     <= t_wide[21:0];
      bad_r[0] <= bad_nxt;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        bad_r[k] <= bad_r[k-1];
      end
    end
    if (en[1]) begin
      t_r1    <= t_r0;
      q400_r1 <= 5'(p400 >> DIV400Y_SH);
    end
    if (en[2]) begin
      d_r2 <= 18'(t_r1 - 22'(22'(q400_r1) * 22'(DAYS_400Y)));
      y_r2 <= 14'(14'(q400_r1) * 14'(YEARS_400)) + 14'd1;
    end
    if (en[3]) begin
      d_r3 <= 16'(d_r2 - 18'(18'(qc) * 18'(DAYS_100Y)));
      y_r3 <= y_r2 + 14'(14'(qc) * 14'(YEARS_100));
    end
    if (en[4]) begin
      d_r4  <= d_r3;
      q4_r4 <= 5'(p4y >> DIV4Y_SH);
      y_r4  <= y_r3;
    end
    if (en[5]) begin
      d_r5 <= 11'(d_r4 - 16'(16'(q4_r4) * 16'(DAYS_4Y)));
      y_r5 <= y_r4 + 14'(14'(q4_r4) * 14'(YEARS_4));
    end
    if (en[6]) begin
      d_r6 <= 9'(d_r5 - 11'(11'(q1) * 11'(DAYS_1Y)));
      y_r6 <= y_r5 + 14'(q1);
    end
    if (en[7]) begin
      d_r7     <= d_r6;
      m0_r7    <= m0_nxt;
      yq100_r7 <= div25(y_r6[13:2]);
      yq400_r7 <= div25(12'(y_r6[13:4]));
      y_r7     <= y_r6;
    end
    if (en[8]) begin
      d_r8    <= d_r7;
      m0_r8   <= m0_r7;
      mshi_r8 <= month_start(lp, m0_r7 + 4'd1);
      mslo_r8 <= month_start(lp, m0_r7);
      y_r8    <= y_r7;
    end
    if (en[9]) begin
      y_r9   <= bad_r[8] ? '0 : y_r8;
      mon_r9 <= bad_r[8] ? '0 : mon_nxt;
      day_r9 <= bad_r[8] ? '0 : 5'(dd + 9'd1);
    end
  end

  assign year  = y_r9;
  assign month = mon_r9;
  assign day   = day_r9;
  assign bad   = bad_r[NSTG-1];

endmodule

>>> rtl/civil_date_serial_converter_unit.sv
// Civil date <-> serial day number converter, pipelined.
// Input channel (in_*): in_command 0 encodes in_year/in_month/in_day to a
// serial day (day 1 = 1899-12-31), 1 decodes in_serial to a date. The item
// transfers on a clock edge with in_valid and in_ready both high.
// Result channel (out_*): out_serial for encode, out_year/out_month/out_day
// for decode, out_status 0 ok, 1 bad month, 2 bad day, 3 bad year,
// 4 serial out of range; fields of the other direction read 0.
// Pipeline: ten register stages. Throughput: one item per cycle while
// out_ready is high, set by the ten-stage pipeline where every stage
// takes a new item each cycle unless a stall reaches it.
// Each stage holds a valid bit and advances when it is empty or the stage
// after it advances, so a stalled out_ready holds the last stage while
// empty stages ahead still fill; in_ready drops only when all stages hold
// items. Nothing is lost or repeated across a stall.
// Reset (rst_n low, synchronous) clears the valid bits: the pipeline is
// empty and out_valid is low after reset; no other start-up delay.
// Depends on dcsc_pkg, dcsc_encode, dcsc_decode.
module civil_date_serial_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [22:0] in_serial,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [22:0] out_serial,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [2:0]  out_status
);
  import dcsc_pkg::*;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] cmd_r;
  stg_en_t         en;

  logic [22:0] enc_serial;
  status_t     enc_status;
  logic [13:0] dec_year;
  logic [3:0]  dec_month;
  logic [4:0]  dec_day;
  logic        dec_bad;
  logic        cmd_out;

  // a stage advances when empty or when the next stage advances
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cmd_r[0] <= in_command;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        cmd_r[k] <= cmd_r[k-1];
      end
    end
  end

  dcsc_encode u_encode (
    .clk    (clk),
    .en     (en),
    .year   (in_year),
    .month  (in_month),
    .day    (in_day),
    .serial (enc_serial),
    .status (enc_status)
  );

  dcsc_decode u_decode (
    .clk    (clk),
    .en     (en),
    .serial (in_serial),
    .year   (dec_year),
    .month  (dec_month),
    .day    (dec_day),
    .bad    (dec_bad)
  );

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];
  assign cmd_out   = cmd_r[NSTG-1];

  assign out_serial = cmd_out ? '0 : enc_serial;
  assign out_year   = cmd_out ? dec_year : '0;
  assign out_month  = cmd_out ? dec_month : '0;
  assign out_day    = cmd_out ? dec_day : '0;
  assign out_status = cmd_out ? (dec_bad ? ST_BAD_SERIAL : ST_OK) : enc_status;

endmodule
